// File: design/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg
// Shared constants and types of the bit run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package brle_pkg;

    localparam int DATA_W  = 8;     // source byte and code byte
    localparam int LEN_W   = 16;    // byte counters and limit
    localparam int CODE_W  = 3;     // one run-length code
    localparam int PEND_W  = 7;     // bits of a partial code byte
    localparam int ACC_W   = 40;    // pending bits plus nine codes, byte aligned
    localparam int NB_W    = 6;     // bit count of the accumulator
    localparam int NF_W    = 3;     // count of full bytes per item
    localparam int OUT_W   = DATA_W + LEN_W;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic [CODE_W-1:0] RUN_MAX = 3'd7;
    localparam logic [LEN_W-1:0]  MAX_OUT_RST = 16'hFFFF;

    // Work for the back end from one source byte: left-aligned code bits.
    typedef struct packed {
        logic [ACC_W-1:0] bits;
        logic [NF_W-1:0]  nfull;   // complete bytes at the top of bits
        logic             last;    // byte after the full ones is the final one
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage : brle_pkg

`default_nettype wire

// File: design/brle_front.sv
// ----------------------------------------------------------------------------
// brle_front
// Accepts source bytes, tracks runs and turns each byte into packed code bits.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [brle_pkg::DATA_W-1:0] i_data,
    input  wire logic                        i_last,
    input  wire brle_pkg::t_q_status         i_q_status,
    output logic                             o_ready,
    output logic                             o_push,
    output brle_pkg::t_bundle                o_bundle
);

    logic                              r_run_bit, n_run_bit;
    logic [brle_pkg::CODE_W-1:0]       r_run_cnt, n_run_cnt;
    logic [brle_pkg::PEND_W-1:0]       r_pend,    n_pend;
    logic [2:0]                        r_pend_n,  n_pend_n;

    always_comb begin
        logic                          rb;
        logic [brle_pkg::CODE_W-1:0]   rc;
        logic [brle_pkg::ACC_W-1:0]    acc;
        logic [brle_pkg::NB_W-1:0]     nb;
        logic [2:0]                    rem;

        rb  = r_run_bit;
        rc  = r_run_cnt;
        acc = brle_pkg::ACC_W'(r_pend);
        nb  = brle_pkg::NB_W'(r_pend_n);

        for (int j = brle_pkg::DATA_W - 1; j >= 0; j--) begin
            if (i_data[j] == rb) begin
                if (rc == brle_pkg::RUN_MAX - 3'd1) begin
                    // run hits the limit: code it now and flip
                    acc = (acc << brle_pkg::CODE_W) | brle_pkg::ACC_W'(brle_pkg::RUN_MAX);
                    nb  = nb + brle_pkg::NB_W'(brle_pkg::CODE_W);
                    rb  = ~rb;
                    rc  = '0;
                end else begin
                    rc  = rc + 3'd1;
                end
            end else begin
                acc = (acc << brle_pkg::CODE_W) | brle_pkg::ACC_W'(rc);
                nb  = nb + brle_pkg::NB_W'(brle_pkg::CODE_W);
                rb  = ~rb;
                rc  = 3'd1;
            end
        end

        if (i_last) begin
            acc = (acc << brle_pkg::CODE_W) | brle_pkg::ACC_W'(rc);
            nb  = nb + brle_pkg::NB_W'(brle_pkg::CODE_W);
        end

        rem = nb[2:0];
        o_bundle.bits  = acc << (brle_pkg::NB_W'(brle_pkg::ACC_W) - nb);
        o_bundle.nfull = nb[brle_pkg::NB_W-1:3];
        o_bundle.last  = i_last;

        if (i_last) begin
            n_run_bit = 1'b0;
            n_run_cnt = '0;
            n_pend    = '0;
            n_pend_n  = '0;
        end else begin
            n_run_bit = rb;
            n_run_cnt = rc;
            n_pend    = acc[brle_pkg::PEND_W-1:0] & ~({brle_pkg::PEND_W{1'b1}} << rem);
            n_pend_n  = rem;
        end
    end

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_bit <= 1'b0;
            r_run_cnt <= '0;
            r_pend    <= '0;
            r_pend_n  <= '0;
        end else if (o_push) begin
            r_run_bit <= n_run_bit;
            r_run_cnt <= n_run_cnt;
            r_pend    <= n_pend;
            r_pend_n  <= n_pend_n;
        end
    end

endmodule : brle_front

`default_nettype wire

// File: design/brle_queue.sv
// ----------------------------------------------------------------------------
// brle_queue
// Two-entry queue of code bundles between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire brle_pkg::t_bundle  i_data,
    input  wire logic               i_pop,
    output brle_pkg::t_bundle       o_head,
    output brle_pkg::t_q_status     o_status
);

    localparam logic [brle_pkg::Q_AW:0] DEPTH = (brle_pkg::Q_AW + 1)'(brle_pkg::Q_DEPTH);

    brle_pkg::t_bundle            r_mem [brle_pkg::Q_DEPTH];
    logic [brle_pkg::Q_AW-1:0]    r_wr_ptr;
    logic [brle_pkg::Q_AW-1:0]    r_rd_ptr;
    logic [brle_pkg::Q_AW:0]      r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == DEPTH);
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule : brle_queue

`default_nettype wire

// File: design/brle_back.sv
// ----------------------------------------------------------------------------
// brle_back
// Emits code bytes one beat at a time, counts them and handles overflow/drop.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire brle_pkg::t_bundle           i_head,
    input  wire brle_pkg::t_q_status         i_q_status,
    input  wire logic [brle_pkg::LEN_W-1:0]  i_max,
    input  wire logic                        i_tready,
    output logic                             o_pop,
    output logic                             o_tvalid,
    output logic [brle_pkg::OUT_W-1:0]       o_tdata,   // out_byte, total_bytes
    output logic                             o_tlast,   // is_final
    output logic                             o_tuser    // overflow
);

    logic                          r_ovalid,   n_ovalid;
    logic [brle_pkg::OUT_W-1:0]    r_odata,    n_odata;
    logic                          r_olast,    n_olast;
    logic                          r_ouser,    n_ouser;
    logic [brle_pkg::NF_W-1:0]     r_idx,      n_idx;
    logic [brle_pkg::LEN_W-1:0]    r_bytes,    n_bytes;
    logic                          r_drop,     n_drop;
    logic                          r_ovf_pend, n_ovf_pend;

    logic                          can_load;
    logic [brle_pkg::ACC_W-1:0]    head_sh;
    logic [brle_pkg::DATA_W-1:0]   head_byte;
    logic [brle_pkg::LEN_W-1:0]    bytes_inc;

    assign can_load  = !r_ovalid || i_tready;
    assign head_sh   = i_head.bits << {r_idx, 3'b000};
    assign head_byte = head_sh[brle_pkg::ACC_W-1 -: brle_pkg::DATA_W];
    assign bytes_inc = r_bytes + brle_pkg::LEN_W'(1);

    always_comb begin
        n_ovalid   = r_ovalid;
        n_odata    = r_odata;
        n_olast    = r_olast;
        n_ouser    = r_ouser;
        n_idx      = r_idx;
        n_bytes    = r_bytes;
        n_drop     = r_drop;
        n_ovf_pend = r_ovf_pend;
        o_pop      = 1'b0;

        if (r_ovalid && i_tready) begin
            n_ovalid = 1'b0;
        end

        if (!i_q_status.empty) begin
            if (r_ovf_pend) begin
                if (can_load) begin
                    n_ovalid   = 1'b1;
                    n_odata    = {r_bytes, brle_pkg::DATA_W'(0)};
                    n_olast    = 1'b1;
                    n_ouser    = 1'b1;
                    n_ovf_pend = 1'b0;
                    n_bytes    = '0;
                    n_drop     = !i_head.last;
                    n_idx      = '0;
                    o_pop      = 1'b1;
                end
            end else if (r_drop) begin
                o_pop = 1'b1;
                if (i_head.last) begin
                    n_drop = 1'b0;
                end
            end else if (r_idx < i_head.nfull) begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_odata  = {brle_pkg::LEN_W'(0), head_byte};
                    n_olast  = 1'b0;
                    n_ouser  = 1'b0;
                    n_bytes  = bytes_inc;
                    if (bytes_inc >= i_max) begin
                        n_ovf_pend = 1'b1;
                    end else if ((r_idx + 3'd1) == i_head.nfull && !i_head.last) begin
                        o_pop = 1'b1;
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end else if (i_head.last) begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_odata  = {bytes_inc, head_byte};
                    n_olast  = 1'b1;
                    n_ouser  = 1'b0;
                    n_bytes  = '0;
                    n_idx    = '0;
                    o_pop    = 1'b1;
                end
            end else begin
                // no full byte in this item
                o_pop = 1'b1;
                n_idx = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid   <= 1'b0;
            r_idx      <= '0;
            r_bytes    <= '0;
            r_drop     <= 1'b0;
            r_ovf_pend <= 1'b0;
        end else begin
            r_ovalid   <= n_ovalid;
            r_idx      <= n_idx;
            r_bytes    <= n_bytes;
            r_drop     <= n_drop;
            r_ovf_pend <= n_ovf_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_ouser <= n_ouser;
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;
    assign o_tuser  = r_ouser;

    // overflow beat still owns its bundle at the queue head
    a_ovf_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf_pend |-> !i_q_status.empty)
        else $error("overflow pending without a bundle");

    a_ovf_not_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf_pend |-> !r_drop)
        else $error("overflow pending while dropping");

    a_ovf_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ouser) |-> (r_olast && r_odata[brle_pkg::DATA_W-1:0] == '0))
        else $error("overflow beat malformed");

    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_bytes == '0))
        else $error("byte count not cleared while dropping");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_status.empty)
        else $error("pop from empty queue");

endmodule : brle_back

`default_nettype wire

// File: design/bit_run_length_encoder_top.sv
// ----------------------------------------------------------------------------
// bit_run_length_encoder_top
// Bit run-length encoder with 3-bit run codes packed into output bytes.
// ----------------------------------------------------------------------------
//  channel   dir  beat payload
//  s_axis    in   tdata = data_byte[7:0], tlast = is_last
//  m_axis    out  tdata = out_byte[7:0], total_bytes[23:8];
//                 tlast = is_final, tuser = overflow
//  cfg       in   data = max_out_bytes[15:0], always ready
//
//  A source byte is taken into the front end while the queue is not full; it
//  yields 0 to 5 result beats, emitted one per cycle by the back end while
//  m_axis is ready; back-pressure holds a beat in the output register.
//  A two-entry queue lets the front accept while the back drains or stalls.
//  Synchronous active-low reset; no clearing pass, ready as soon as reset
//  is released.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_run_length_encoder_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [brle_pkg::DATA_W-1:0]   i_s_axis_tdata,   // data_byte
    input  wire logic                          i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [brle_pkg::OUT_W-1:0]         o_m_axis_tdata,   // out_byte, total_bytes
    output logic                               o_m_axis_tlast,   // is_final
    output logic                               o_m_axis_tuser,   // overflow
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [brle_pkg::LEN_W-1:0]    i_cfg_data
);

    logic [brle_pkg::LEN_W-1:0] r_max;
    logic                       push;
    logic                       pop;
    brle_pkg::t_bundle          push_data;
    brle_pkg::t_bundle          head;
    brle_pkg::t_q_status        q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= brle_pkg::MAX_OUT_RST;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    brle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_data     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .i_q_status (q_status),
        .o_ready    (o_s_axis_tready),
        .o_push     (push),
        .o_bundle   (push_data)
    );

    brle_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_data),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    brle_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .i_max      (r_max),
        .i_tready   (i_m_axis_tready),
        .o_pop      (pop),
        .o_tvalid   (o_m_axis_tvalid),
        .o_tdata    (o_m_axis_tdata),
        .o_tlast    (o_m_axis_tlast),
        .o_tuser    (o_m_axis_tuser)
    );

endmodule : bit_run_length_encoder_top

`default_nettype wire
